// ===== rtl/core/interrupt_controller_regs_defines.svh =====
// Assertion macros shared by the interrupt controller register block.
`ifndef INTERRUPT_CONTROLLER_REGS_DEFINES_SVH
`define INTERRUPT_CONTROLLER_REGS_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset.
`define ICR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ICR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define ICR_ASSERT(lbl, prop, msg)
`define ICR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== rtl/core/icr_pkg.sv =====
// Types and constants of the interrupt controller register block.
`default_nettype none

package icr_pkg;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_LINE  = 2'd2
    } op_t;

    // Register group of the pending and mask word window, from addr[8:7].
    typedef enum logic [1:0] {
        GRP_CLEAR   = 2'b01,
        GRP_DISABLE = 2'b10,
        GRP_ENABLE  = 2'b11
    } grp_t;

    localparam int unsigned MAX_SRC   = 256;
    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned WIDX_W    = 3;

    localparam logic [15:0] OFS_INFO    = 16'h0004;
    localparam logic [15:0] OFS_ACK     = 16'h2004;
    // addr[15:10] of the affinity window at 0x3000.
    localparam logic [5:0]  AFF_PAGE    = 6'h0C;
    // addr[15:9] of the clear/disable/enable window at 0x4080..0x41ff.
    localparam logic [6:0]  WORD_PAGE   = 7'h20;
    localparam logic [3:0]  ACK_TYPE_HW = 4'h1;

    typedef struct packed {
        logic              rd;
        logic              wr;
        logic              line;
        logic              info;
        logic              ack;
        logic              aff;
        logic              word;
        grp_t              grp;
        logic [WIDX_W-1:0] widx;
        logic              err;
    } dec_t;

endpackage

`default_nettype wire

// ===== rtl/core/icr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module icr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/icr_decode.sv =====
// Register offset decode for the interrupt controller register block.
`default_nettype none

module icr_decode import icr_pkg::*; #(
    parameter int unsigned NUM_SOURCES = 256
) (
    input  wire logic [1:0]  op,
    input  wire logic [15:0] addr,
    output dec_t             dec
);

    localparam int unsigned WORD_COUNT = (NUM_SOURCES + WORD_BITS - 1) / WORD_BITS;

    logic is_bus;
    logic aligned;
    logic hit_info;
    logic hit_ack;
    logic hit_aff;
    logic hit_word;

    always_comb begin
        is_bus   = (op == OP_READ) || (op == OP_WRITE);
        aligned  = (addr[1:0] == 2'b00);
        hit_info = (addr == OFS_INFO);
        hit_ack  = (addr == OFS_ACK);
        hit_aff  = aligned && (addr[15:10] == AFF_PAGE)
                   && ({1'b0, addr[9:2]} < 9'(NUM_SOURCES));
        hit_word = aligned && (addr[15:9] == WORD_PAGE) && (addr[8:7] != 2'b00)
                   && (addr[6:2] < 5'(WORD_COUNT));

        dec.rd   = (op == OP_READ);
        dec.wr   = (op == OP_WRITE);
        dec.line = (op == OP_LINE);
        dec.info = is_bus && hit_info;
        dec.ack  = is_bus && hit_ack;
        dec.aff  = is_bus && hit_aff;
        dec.word = is_bus && hit_word;
        dec.grp  = grp_t'(addr[8:7]);
        dec.widx = addr[4:2];
        dec.err  = is_bus && !(hit_info || hit_ack || hit_aff || hit_word);
    end

endmodule

`default_nettype wire

// ===== rtl/core/icr_prio.sv =====
// Lowest-index priority encoder over the ready sources.
`default_nettype none

module icr_prio import icr_pkg::*; #(
    parameter int unsigned NUM_SOURCES = 256
) (
    input  wire logic [NUM_SOURCES-1:0] ready_vec,
    output logic                        found,
    output logic [7:0]                  idx
);

    localparam int unsigned WORD_COUNT = (NUM_SOURCES + WORD_BITS - 1) / WORD_BITS;

    logic [MAX_SRC-1:0]      ready_pad;
    logic [WORD_COUNT-1:0]   word_any;
    logic [WIDX_W-1:0]       sel_word;
    logic [WORD_BITS-1:0]    word_bits;
    logic [WORD_BITS-1:0]    low_bit;
    logic [4:0]              bit_pos;

    always_comb begin
        ready_pad = MAX_SRC'(ready_vec);
        for (int w = 0; w < WORD_COUNT; w++) begin
            word_any[w] = |ready_pad[w*WORD_BITS +: WORD_BITS];
        end

        // Scan words from the top down so the lowest busy word wins.
        sel_word = '0;
        for (int w = WORD_COUNT - 1; w >= 0; w--) begin
            if (word_any[w]) begin
                sel_word = WIDX_W'(w);
            end
        end

        word_bits = ready_pad[sel_word*WORD_BITS +: WORD_BITS];
        low_bit   = word_bits & (~word_bits + 32'd1);

        bit_pos = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (low_bit[b]) begin
                bit_pos = bit_pos | 5'(b);
            end
        end

        found = |word_any;
        idx   = {sel_word, bit_pos};
    end

endmodule

`default_nettype wire

// ===== rtl/core/interrupt_controller_regs.sv =====
// Top level of the interrupt controller register block.
//
//  channel  | direction | tdata (low bit up)                         | tuser
//  ---------+-----------+--------------------------------------------+--------------
//  s_       | in        | addr, wdata, source_index, source_level    | op
//  m_       | out       | rdata, irq_request                         | access_error
//
// One item a cycle while the result side takes results: an item sits in the
// input register, where decode, the priority encoder and the state update
// run, then moves to the result register. The affinity RAM is read as the
// item is accepted, so its registered data lines up with the input register.
// Reset: pending bits clear, every source masked, affinity reads as zero
// through per-entry valid bits; s_tready stays low during reset and the block
// takes items the cycle after reset.
// Stalls: a full result register holds the input register; while a result
// waits the input register still takes one more item, so up to two items are
// in flight.
`default_nettype none
`include "interrupt_controller_regs_defines.svh"

module interrupt_controller_regs import icr_pkg::*; #(
    parameter int unsigned NUM_SOURCES = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] addr, [47:16] wdata, [55:48] source_index, [56] source_level
    input  wire logic [63:0] s_tdata,
    // [1:0] op
    input  wire logic [1:0]  s_tuser,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] rdata, [32] irq_request
    output logic      [39:0] m_tdata,
    // [0] access_error
    output logic             m_tuser
);

    localparam int unsigned AW = $clog2(NUM_SOURCES);

    // Input register.
    logic        in_valid_reg;
    logic [1:0]  op_reg;
    logic [15:0] addr_reg;
    logic [31:0] wdata_reg;
    logic [7:0]  src_reg;
    logic        lvl_reg;

    // Result register.
    logic        out_valid_reg;
    logic [31:0] rdata_out_reg;
    logic        err_out_reg;
    logic [31:0] rdata_next;

    // Source state.
    logic [NUM_SOURCES-1:0] pend_reg, pend_next;
    logic [NUM_SOURCES-1:0] mask_reg, mask_next;
    logic [NUM_SOURCES-1:0] aff0_reg, aff0_next;
    logic [NUM_SOURCES-1:0] aval_reg, aval_next;

    // Affinity forwarding around the RAM read.
    logic          fwd_hit_reg;
    logic [7:0]    fwd_data_reg;

    logic          s_accept;
    logic          advance;
    dec_t          dec;
    logic [AW-1:0] aff_idx;
    logic [AW-1:0] ram_raddr;
    logic          ram_we;
    logic [7:0]    ram_rdata;
    logic [7:0]    aff_byte;
    logic          ack_found;
    logic [7:0]    ack_idx;
    logic          src_ok;
    logic          irq_now;
    logic [MAX_SRC-1:0] pend_w;
    logic [MAX_SRC-1:0] mask_w;

    // Advance the input register into the result register when it is free;
    // hold off the input channel during reset.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = aresetn && (!in_valid_reg || advance);
    assign s_accept = s_tvalid && s_tready;

    icr_decode #(.NUM_SOURCES(NUM_SOURCES)) u_decode (
        .op   (op_reg),
        .addr (addr_reg),
        .dec  (dec)
    );

    icr_prio #(.NUM_SOURCES(NUM_SOURCES)) u_prio (
        .ready_vec (pend_reg & ~mask_reg & aff0_reg),
        .found     (ack_found),
        .idx       (ack_idx)
    );

    assign aff_idx   = addr_reg[2 +: AW];
    assign ram_raddr = s_tdata[2 +: AW];
    assign ram_we    = advance && dec.wr && dec.aff;

    icr_ram #(.WIDTH(8), .DEPTH(NUM_SOURCES)) u_aff_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (aff_idx),
        .wdata (wdata_reg[7:0]),
        .re    (s_accept),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Never-written entries read as zero; a write at the accept edge wins
    // over the stale RAM word.
    assign aff_byte = !aval_reg[aff_idx] ? 8'h00
                    : (fwd_hit_reg ? fwd_data_reg : ram_rdata);

    assign pend_w = MAX_SRC'(pend_reg);
    assign mask_w = MAX_SRC'(mask_reg);
    assign src_ok = ({1'b0, src_reg} < 9'(NUM_SOURCES));

    // Read data of the item in the input register, from the state it sees.
    always_comb begin
        rdata_next = '0;
        if (dec.rd && !dec.err) begin
            if (dec.info) begin
                rdata_next = {16'h0000, 16'(NUM_SOURCES)};
            end else if (dec.ack) begin
                if (ack_found) begin
                    rdata_next = {12'h000, ACK_TYPE_HW, 8'h00, ack_idx};
                end
            end else if (dec.aff) begin
                rdata_next = {24'h000000, aff_byte};
            end else if (dec.word) begin
                if (dec.grp == GRP_CLEAR) begin
                    rdata_next = pend_w[dec.widx*WORD_BITS +: WORD_BITS];
                end else begin
                    rdata_next = mask_w[dec.widx*WORD_BITS +: WORD_BITS];
                end
            end
        end
    end

    // State update, applied as the item leaves the input register.
    always_comb begin
        pend_next = pend_reg;
        mask_next = mask_reg;
        aff0_next = aff0_reg;
        aval_next = aval_reg;
        if (advance) begin
            if (dec.line && src_ok) begin
                for (int j = 0; j < NUM_SOURCES; j++) begin
                    if (8'(j) == src_reg) begin
                        pend_next[j] = lvl_reg;
                    end
                end
            end
            if (dec.wr && dec.word) begin
                for (int j = 0; j < NUM_SOURCES; j++) begin
                    if ((WIDX_W'(j >> 5) == dec.widx) && wdata_reg[j & 31]) begin
                        case (dec.grp)
                            GRP_CLEAR:   pend_next[j] = 1'b0;
                            GRP_DISABLE: mask_next[j] = 1'b1;
                            GRP_ENABLE:  mask_next[j] = 1'b0;
                            default:     pend_next[j] = pend_reg[j];
                        endcase
                    end
                end
            end
            if (dec.rd && dec.ack && ack_found) begin
                for (int j = 0; j < NUM_SOURCES; j++) begin
                    if (8'(j) == ack_idx) begin
                        mask_next[j] = 1'b1;
                    end
                end
            end
            if (dec.wr && dec.aff) begin
                for (int j = 0; j < NUM_SOURCES; j++) begin
                    if (AW'(j) == aff_idx) begin
                        aff0_next[j] = wdata_reg[0];
                        aval_next[j] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pend_reg      <= '0;
            mask_reg      <= '1;
            aff0_reg      <= '0;
            aval_reg      <= '0;
            fwd_hit_reg   <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            mask_reg <= mask_next;
            aff0_reg <= aff0_next;
            aval_reg <= aval_next;

            if (s_accept) begin
                in_valid_reg <= 1'b1;
                fwd_hit_reg  <= ram_we && (aff_idx == ram_raddr);
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg       <= s_tuser;
            addr_reg     <= s_tdata[15:0];
            wdata_reg    <= s_tdata[47:16];
            src_reg      <= s_tdata[55:48];
            lvl_reg      <= s_tdata[56];
            fwd_data_reg <= wdata_reg[7:0];
        end
        if (advance) begin
            rdata_out_reg <= rdata_next;
            err_out_reg   <= dec.err;
        end
    end

    // State only moves when a result is loaded, so while a result waits the
    // state is exactly what that item left behind.
    assign irq_now = |(pend_reg & ~mask_reg & aff0_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0000000, irq_now, rdata_out_reg};
    assign m_tuser  = err_out_reg;

    `ICR_ASSERT(a_stall_blocks_input, (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready, "input taken while result stalled")
    `ICR_ASSERT(a_ack_masks_source, (advance && dec.rd && dec.ack && ack_found) |=> mask_w[$past(ack_idx)], "acknowledged source left unmasked")
    `ICR_ASSERT(a_error_reads_zero, (out_valid_reg && err_out_reg) |-> (rdata_out_reg == 32'h0), "error result carries read data")
    `ICR_ASSERT_ALWAYS(a_reset_masks_all, !aresetn |=> (mask_reg == '1), "reset left a source unmasked")

endmodule

`default_nettype wire

// ===== test/interrupt_controller_regs_test.sv =====
// Self-checking testbench for the interrupt controller register block.
module interrupt_controller_regs_test;
    import icr_pkg::*;

    localparam int unsigned NUM_SRC        = 256;
    localparam int unsigned RANDOM_ITEMS   = 1150;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned TAIL_CYCLES    = 16;

    // Register offsets of the windows; INFO and ACK come from the package.
    localparam logic [15:0] OFS_AFFINITY = 16'h3000;
    localparam logic [15:0] OFS_CLEAR    = 16'h4080;
    localparam logic [15:0] OFS_DISABLE  = 16'h4100;
    localparam logic [15:0] OFS_ENABLE   = 16'h4180;
    localparam logic [15:0] WORD_WINDOW  = 16'h0180;
    // Op code the block leaves unused.
    localparam logic [1:0]  OP_NONE      = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] addr;
        logic [31:0] wdata;
        logic [7:0]  src;
        logic        lvl;
    } access_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic        irq;
        logic        err;
    } reply_t;

    // One directed row: the access, and a typed reply where fixed is set.
    typedef struct packed {
        access_t acc;
        logic    fixed;
        reply_t  want;
    } row_t;

    localparam int N_DIRECTED = 25;
    localparam reply_t NO_REPLY = '{32'h0, 1'b0, 1'b0};
    localparam row_t DIRECTED [N_DIRECTED] = '{
        // state straight out of reset
        '{'{OP_READ,  OFS_INFO, 32'h0, 8'h00, 1'b0}, 1'b1, '{32'd256, 1'b0, 1'b0}},
        '{'{OP_READ,  OFS_ACK, 32'h0, 8'h00, 1'b0}, 1'b1, '{32'h0, 1'b0, 1'b0}},
        '{'{OP_WRITE, OFS_INFO, 32'hffffffff, 8'h00, 1'b0}, 1'b1, '{32'h0, 1'b0, 1'b0}},
        // unmapped, unaligned, the disable word after reset and a word index past the last source
        '{'{OP_READ,  16'hffff, 32'h0, 8'h00, 1'b0}, 1'b1, '{32'h0, 1'b0, 1'b1}},
        '{'{OP_WRITE, OFS_AFFINITY + 16'h2, 32'hffffffff, 8'h00, 1'b0}, 1'b1,
          '{32'h0, 1'b0, 1'b1}},
        '{'{OP_READ,  OFS_DISABLE, 32'h0, 8'h00, 1'b0}, 1'b1, '{32'hffffffff, 1'b0, 1'b0}},
        '{'{OP_READ,  OFS_ENABLE + 16'h3c, 32'h0, 8'h00, 1'b0}, 1'b1, '{32'h0, 1'b0, 1'b1}},
        // raise source 0, route it, unmask it, read its routing, then acknowledge twice
        '{'{OP_LINE,  16'h0, 32'h0, 8'h00, 1'b1}, 1'b1, '{32'h0, 1'b0, 1'b0}},
        '{'{OP_WRITE, OFS_AFFINITY, 32'hffffffff, 8'h00, 1'b0}, 1'b1, '{32'h0, 1'b0, 1'b0}},
        '{'{OP_WRITE, OFS_ENABLE, 32'h1, 8'h00, 1'b0}, 1'b1, '{32'h0, 1'b1, 1'b0}},
        '{'{OP_READ,  OFS_AFFINITY, 32'h0, 8'h00, 1'b0}, 1'b1, '{32'hff, 1'b1, 1'b0}},
        '{'{OP_READ,  OFS_ACK, 32'h0, 8'h00, 1'b0}, 1'b1, '{32'h00010000, 1'b0, 1'b0}},
        '{'{OP_READ,  OFS_ACK, 32'h0, 8'h00, 1'b0}, 1'b1, '{32'h0, 1'b0, 1'b0}},
        // top source, read-only write, unused op, enable, clear and disable words, unused group
        '{'{OP_LINE,  16'hffff, 32'hffffffff, 8'hff, 1'b1}, 1'b0, NO_REPLY},
        '{'{OP_WRITE, OFS_AFFINITY + 16'h3fc, 32'hfffffe01, 8'h00, 1'b0}, 1'b0, NO_REPLY},
        '{'{OP_WRITE, OFS_ENABLE + 16'h1c, 32'h80000000, 8'h00, 1'b0}, 1'b0, NO_REPLY},
        '{'{OP_READ,  OFS_CLEAR + 16'h1c, 32'h0, 8'h00, 1'b0}, 1'b0, NO_REPLY},
        '{'{OP_WRITE, OFS_ACK, 32'hffffffff, 8'h00, 1'b0}, 1'b0, NO_REPLY},
        '{'{OP_READ,  OFS_ACK, 32'h0, 8'h00, 1'b0}, 1'b0, NO_REPLY},
        '{'{OP_NONE,  16'hffff, 32'hffffffff, 8'hff, 1'b1}, 1'b0, NO_REPLY},
        '{'{OP_WRITE, OFS_ENABLE, 32'hffffffff, 8'h00, 1'b0}, 1'b0, NO_REPLY},
        '{'{OP_WRITE, OFS_CLEAR, 32'hffffffff, 8'h00, 1'b0}, 1'b0, NO_REPLY},
        '{'{OP_LINE,  16'h0, 32'h0, 8'hff, 1'b0}, 1'b0, NO_REPLY},
        '{'{OP_WRITE, OFS_DISABLE, 32'hffffffff, 8'h00, 1'b0}, 1'b0, NO_REPLY},
        '{'{OP_READ,  16'h4000, 32'h0, 8'h00, 1'b0}, 1'b1, '{32'h0, 1'b0, 1'b1}}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;

    // Shadow of the controller state.
    bit          src_pending [NUM_SRC];
    bit          src_masked  [NUM_SRC];
    logic [7:0]  src_affinity [NUM_SRC];

    reply_t      due_replies [$];
    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;
    logic [15:0] stall_pat    = 16'hffff;
    int unsigned stall_age    = 0;

    always #2 aclk = ~aclk;

    interrupt_controller_regs #(.NUM_SOURCES(NUM_SRC)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    function automatic bit source_fires(int s);
        return src_pending[s] && !src_masked[s] && src_affinity[s][0];
    endfunction

    // Apply one access to the shadow state and return the reply it causes.
    function automatic reply_t apply_access(access_t acc);
        reply_t      r;
        int unsigned a;
        int unsigned w;
        int          s;
        bit          wr;
        bit          found;
        logic [31:0] word;
        grp_t        grp;
        r     = '0;
        a     = acc.addr;
        wr    = (acc.op == OP_WRITE);
        found = 1'b0;
        word  = '0;
        if (acc.op == OP_READ || acc.op == OP_WRITE) begin
            if (acc.addr == OFS_INFO) begin
                if (!wr) r.rdata = NUM_SRC & 32'hffff;
            end else if (acc.addr == OFS_ACK) begin
                // hand out the lowest qualifying source and mask it
                if (!wr) begin
                    for (s = 0; s < NUM_SRC; s++) begin
                        if (!found && source_fires(s)) begin
                            found         = 1'b1;
                            src_masked[s] = 1'b1;
                            r.rdata       = {12'h0, ACK_TYPE_HW, 16'(s)};
                        end
                    end
                end
            end else if (acc.addr[1:0] != 2'b00) begin
                r.err = 1'b1;
            end else if (a >= OFS_AFFINITY && a < OFS_AFFINITY + 4 * NUM_SRC) begin
                s = (a - OFS_AFFINITY) >> 2;
                if (wr) src_affinity[s] = acc.wdata[7:0];
                else r.rdata = {24'h0, src_affinity[s]};
            end else if (a >= OFS_CLEAR && a < OFS_CLEAR + WORD_WINDOW) begin
                w = ((a - OFS_CLEAR) >> 2) & 31;
                if (w * 32 >= NUM_SRC) begin
                    r.err = 1'b1;
                end else begin
                    grp = grp_t'(acc.addr[8:7]);
                    for (int b = 0; b < 32; b++) begin
                        s = w * 32 + b;
                        if (s < NUM_SRC) begin
                            case (grp)
                                GRP_CLEAR: begin
                                    if (wr && acc.wdata[b]) src_pending[s] = 1'b0;
                                    word[b] = src_pending[s];
                                end
                                GRP_DISABLE: begin
                                    if (wr && acc.wdata[b]) src_masked[s] = 1'b1;
                                    word[b] = src_masked[s];
                                end
                                default: begin
                                    if (wr && acc.wdata[b]) src_masked[s] = 1'b0;
                                    word[b] = src_masked[s];
                                end
                            endcase
                        end
                    end
                    if (!wr) r.rdata = word;
                end
            end else begin
                r.err = 1'b1;
            end
        end else if (acc.op == OP_LINE) begin
            if (acc.src < NUM_SRC) src_pending[acc.src] = acc.lvl;
        end
        // request line reflects the state after this access
        for (s = 0; s < NUM_SRC; s++)
            if (source_fires(s)) r.irq = 1'b1;
        return r;
    endfunction

    // Favor a handful of sources so that pending, unmask and routing meet.
    function automatic logic [7:0] pick_source();
        if ($urandom_range(0, 9) >= 6) return 8'($urandom);
        case ($urandom_range(0, 10))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd2;
            3:       return 8'd31;
            4:       return 8'd32;
            5:       return 8'd63;
            6:       return 8'd127;
            7:       return 8'd128;
            8:       return 8'd200;
            9:       return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    function automatic access_t random_access();
        access_t     acc;
        logic [7:0]  s;
        logic [15:0] base;
        int          r;
        // start from noise in every field but the op, then shape what matters
        acc.op    = OP_READ;
        acc.addr  = 16'($urandom);
        acc.wdata = $urandom;
        acc.src   = 8'($urandom);
        acc.lvl   = 1'($urandom);
        s = pick_source();
        r = $urandom_range(0, 99);
        if (r < 30) begin
            acc.op  = OP_LINE;
            acc.src = s;
            acc.lvl = ($urandom_range(0, 99) < 65);
        end else if (r < 45) begin
            acc.addr = OFS_ACK;
        end else if (r < 57) begin
            acc.op   = OP_WRITE;
            acc.addr = OFS_AFFINITY + {6'h0, s, 2'b00};
            if ($urandom_range(0, 9) < 7) acc.wdata[0] = 1'b1;
        end else if (r < 77) begin
            acc.op = OP_WRITE;
            if (r < 67) base = OFS_ENABLE;
            else if (r < 72) base = OFS_DISABLE;
            else base = OFS_CLEAR;
            acc.addr = base + {11'h0, s[7:5], 2'b00};
            if ($urandom_range(0, 1) == 1) acc.wdata = 32'h1 << s[4:0];
        end else if (r < 87) begin
            if ($urandom_range(0, 1) == 1)
                acc.addr = OFS_AFFINITY + {6'h0, s, 2'b00};
            else
                acc.addr = OFS_CLEAR + 16'($urandom_range(0, 2)) * 16'h80
                           + 16'($urandom_range(0, 7)) * 16'h4;
        end else if (r < 90) begin
            acc.op   = ($urandom_range(0, 1) == 1) ? OP_WRITE : OP_READ;
            acc.addr = ($urandom_range(0, 1) == 1) ? OFS_INFO : OFS_ACK;
        end else if (r < 97) begin
            // stray offsets, many of them near the window edges
            acc.op = ($urandom_range(0, 1) == 1) ? OP_WRITE : OP_READ;
            case ($urandom_range(0, 2))
                0:       acc.addr = 16'h4000 + 16'($urandom_range(0, 16'h3ff));
                1:       acc.addr = 16'h3300 + 16'($urandom_range(0, 16'h1ff));
                default: ;
            endcase
        end else begin
            acc.op = OP_NONE;
        end
        return acc;
    endfunction

    // Present one access and hold it until the block takes it.
    task automatic send_access(access_t acc, logic fixed, reply_t want);
        reply_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'h0, acc.lvl, acc.src, acc.wdata, acc.addr};
        s_tuser  <= acc.op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = apply_access(acc);
        due_replies.push_back(fixed ? want : r);
    endtask

    // Drop valid for a gap; optionally hold until every reply is back.
    task automatic hold_off(int cycles, bit until_drained);
        s_tvalid <= 1'b0;
        s_tdata  <= {$urandom, $urandom};
        s_tuser  <= 2'($urandom);
        if (until_drained)
            while (due_replies.size() != 0) @(posedge aclk);
        repeat (cycles) @(posedge aclk);
    endtask

    // Stimulus: directed table, then random bursts.
    initial begin
        int burst_left;
        for (int s = 0; s < NUM_SRC; s++) begin
            src_pending[s]  = 1'b0;
            src_masked[s]   = 1'b1;
            src_affinity[s] = 8'h00;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_access(DIRECTED[i].acc, DIRECTED[i].fixed, DIRECTED[i].want);
        hold_off(1, 1'b1);

        burst_left = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (burst_left == 0) begin
                // occasionally starve the block until it has nothing in flight
                hold_off($urandom_range(1, 12), $urandom_range(0, 29) == 0);
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100)
                                                         : $urandom_range(1, 16);
            end
            send_access(random_access(), 1'b0, NO_REPLY);
            burst_left--;
        end

        // drain, then give stray results time to show up
        hold_off(TAIL_CYCLES, 1'b1);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side stalls on a rotating pattern, swapped every so often.
    always @(posedge aclk) begin
        if (stall_age == 0) begin
            case ($urandom_range(0, 4))
                0:       stall_pat <= 16'hffff;
                1:       stall_pat <= 16'h5555;
                2:       stall_pat <= 16'h0001;
                3:       stall_pat <= 16'h00ff;
                default: stall_pat <= 16'($urandom) | 16'h0001;
            endcase
            stall_age <= $urandom_range(20, 120);
        end else begin
            stall_pat <= {stall_pat[0], stall_pat[15:1]};
            stall_age <= stall_age - 1;
        end
        m_tready <= stall_pat[0];
    end

    // Compare each result transfer against the oldest expected reply.
    always @(posedge aclk) begin
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_replies.size() == 0) begin
                $display("%0t: unexpected result, expected none, got rdata %h irq %b err %b",
                         $time, m_tdata[31:0], m_tdata[32], m_tuser);
                mismatches++;
            end else begin
                want = due_replies.pop_front();
                if (m_tdata[31:0] !== want.rdata) begin
                    $display("%0t: rdata expected %h, got %h",
                             $time, want.rdata, m_tdata[31:0]);
                    mismatches++;
                end
                if (m_tdata[32] !== want.irq) begin
                    $display("%0t: irq_request expected %b, got %b",
                             $time, want.irq, m_tdata[32]);
                    mismatches++;
                end
                if (m_tuser !== want.err) begin
                    $display("%0t: access_error expected %b, got %b",
                             $time, want.err, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if no transfer happens for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule
